FILE: design/e2p_pkg.sv
// Package for the exp2 polynomial approximation block.
// Holds the channel payload types, the side-band type of the pipeline and fixed constants.
// No dependencies.
package e2p_pkg;

    localparam int X_WIDTH   = 24;
    localparam int MANT_BITS = 23;
    localparam int EXP_BIAS  = 127;
    localparam int EXP_MIN   = -126;
    localparam int EXP_MAX   = 127;

    localparam logic [31:0] FLOAT_POS_INF = 32'h7F80_0000;

    // Polynomial coefficients scaled by 2^30.
    localparam logic [29:0] COEF4_Q30 = 30'd10327388;
    localparam logic [29:0] COEF3_Q30 = 30'd59597084;
    localparam logic [29:0] COEF2_Q30 = 30'd257941240;
    localparam logic [29:0] COEF1_Q30 = 30'd744261117;

    typedef struct packed {
        logic signed [X_WIDTH-1:0] x_value;
        logic                      last_item;
    } e2p_in_t;

    typedef struct packed {
        logic [31:0] result_bits;
        logic        underflow;
        logic        last_out;
    } e2p_out_t;

    // Exponent handling is settled on entry; this travels beside the polynomial.
    typedef struct packed {
        logic       uflow;
        logic       oflow;
        logic [7:0] exp_field;
        logic       last;
    } e2p_side_t;

    // Brings a 2^30-scaled coefficient to p fraction bits, rounding half up.
    function automatic logic [30:0] coef_scale(input logic [29:0] c30, input int unsigned p);
        logic [31:0] sum;
        int unsigned sh;
        sh = 30 - p;
        if (sh == 0) begin
            return 31'(c30);
        end
        sum = {2'b00, c30} + (32'd1 << (sh - 1));
        return 31'(sum >> sh);
    endfunction

endpackage

FILE: design/e2p_horner_stage.sv
// One registered Horner step: acc_out = round(acc_in * fp_in) + COEF.
// Depends on e2p_pkg for the side-band type.
module e2p_horner_stage #(
    parameter int POLY_FRAC_BITS = 24,
    parameter logic [POLY_FRAC_BITS+1:0] COEF = '0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic [POLY_FRAC_BITS+1:0]   acc_in,
    input  logic [POLY_FRAC_BITS-1:0]   fp_in,
    input  e2p_pkg::e2p_side_t          side_in,
    output logic                        valid_out,
    output logic [POLY_FRAC_BITS+1:0]   acc_out,
    output e2p_pkg::e2p_side_t          side_out
);

    localparam int ACC_W  = POLY_FRAC_BITS + 2;
    localparam int PROD_W = ACC_W + POLY_FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (POLY_FRAC_BITS - 1);

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_rnd;
    logic [ACC_W-1:0]  acc_next;
    logic              valid_reg;
    logic [ACC_W-1:0]  acc_reg;
    e2p_pkg::e2p_side_t side_reg;

    always_comb
    begin
        prod     = PROD_W'(acc_in) * PROD_W'(fp_in);
        prod_rnd = prod + HALF;
        acc_next = ACC_W'(prod_rnd >> POLY_FRAC_BITS) + COEF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            acc_reg  <= acc_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign acc_out   = acc_reg;
    assign side_out  = side_reg;

endmodule

FILE: design/exp2_poly_approx.sv
// Top level of the exp2 polynomial approximation block.
// Depends on e2p_pkg and e2p_horner_stage.
//
// Computes an IEEE-754 single approximation of 2^x for a signed fixed-point x, one item
// per clock cycle sustained while the output is not stalled. The pipeline has six
// register stages: argument split and exponent checks, four Horner steps with one
// multiplier each, and float packing into the output register. The whole pipeline
// advances whenever the output register is empty or being taken, so in_ready follows
// out_ready and a stall holds every stage in place. Arguments whose integer part is
// below -126 give zero with underflow set; an integer part above 127 (only reachable
// with few fraction bits) gives positive infinity.
module exp2_poly_approx #(
    parameter int FRAC_BITS      = 16,
    parameter int POLY_FRAC_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  e2p_pkg::e2p_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output e2p_pkg::e2p_out_t  out_data
);

    localparam int P      = POLY_FRAC_BITS;
    localparam int ACC_W  = P + 2;
    localparam int IW     = e2p_pkg::X_WIDTH - FRAC_BITS;
    localparam int IX_W   = (IW > 8) ? IW + 1 : 10;
    localparam int MB     = e2p_pkg::MANT_BITS;

    localparam logic signed [IX_W-1:0] I_MIN = IX_W'(e2p_pkg::EXP_MIN);
    localparam logic signed [IX_W-1:0] I_MAX = IX_W'(e2p_pkg::EXP_MAX);
    localparam logic signed [IX_W-1:0] BIAS  = IX_W'(e2p_pkg::EXP_BIAS);

    localparam logic [ACC_W-1:0] C4  = ACC_W'(e2p_pkg::coef_scale(e2p_pkg::COEF4_Q30, P));
    localparam logic [ACC_W-1:0] C3  = ACC_W'(e2p_pkg::coef_scale(e2p_pkg::COEF3_Q30, P));
    localparam logic [ACC_W-1:0] C2  = ACC_W'(e2p_pkg::coef_scale(e2p_pkg::COEF2_Q30, P));
    localparam logic [ACC_W-1:0] C1  = ACC_W'(e2p_pkg::coef_scale(e2p_pkg::COEF1_Q30, P));
    localparam logic [ACC_W-1:0] ONE = ACC_W'(1) << P;
    localparam logic [ACC_W-1:0] COEF_TAB [0:3] = '{C3, C2, C1, ONE};

    logic adv;

    // Entry stage signals.
    logic [FRAC_BITS-1:0]     f_in;
    logic [P-1:0]             fp_next;
    logic signed [IX_W-1:0]   ipart_ext;
    logic signed [IX_W-1:0]   exp_sum;
    e2p_pkg::e2p_side_t       side_next;

    logic                     valid_s [0:4];
    e2p_pkg::e2p_side_t       side_s  [0:4];
    logic [ACC_W-1:0]         acc_s   [1:4];
    logic [P-1:0]             fp_s    [0:3];

    logic                     valid0_reg;
    e2p_pkg::e2p_side_t       side0_reg;
    logic [P-1:0]             fp_reg  [0:3];

    // Packing stage signals.
    logic [ACC_W-1:0]         frac_full;
    logic [P-1:0]             frac_sat;
    logic [MB-1:0]            mant;
    e2p_pkg::e2p_out_t        out_next;
    logic                     out_valid_reg;
    e2p_pkg::e2p_out_t        out_data_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Floor of x is the arithmetic shift; the fraction is the low bits.
    assign f_in = in_data.x_value[FRAC_BITS-1:0];

    always_comb
    begin
        ipart_ext = {{(IX_W - IW){in_data.x_value[e2p_pkg::X_WIDTH-1]}},
                     in_data.x_value[e2p_pkg::X_WIDTH-1:FRAC_BITS]};
        exp_sum   = ipart_ext + BIAS;
        side_next.uflow     = (ipart_ext < I_MIN);
        side_next.oflow     = (ipart_ext > I_MAX);
        side_next.exp_field = exp_sum[7:0];
        side_next.last      = in_data.last_item;
    end

    generate
        if (P >= FRAC_BITS) begin : g_fp_widen
            assign fp_next = P'(f_in) << (P - FRAC_BITS);
        end else begin : g_fp_narrow
            assign fp_next = f_in[FRAC_BITS-1:FRAC_BITS-P];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid0_reg <= 1'b0;
        end else if (adv) begin
            valid0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            side0_reg <= side_next;
            fp_reg[0] <= fp_next;
            for (int k = 1; k < 4; k++) begin
                fp_reg[k] <= fp_reg[k-1];
            end
        end
    end

    assign valid_s[0] = valid0_reg;
    assign side_s[0]  = side0_reg;

    generate
        for (genvar k = 0; k < 4; k++) begin : g_fp_tap
            assign fp_s[k] = fp_reg[k];
        end
    endgenerate

    generate
        for (genvar k = 0; k < 4; k++) begin : g_horner
            logic [ACC_W-1:0] acc_in;
            if (k == 0) begin : g_first
                assign acc_in = C4;
            end else begin : g_rest
                assign acc_in = acc_s[k];
            end
            e2p_horner_stage #(
                .POLY_FRAC_BITS (P),
                .COEF           (COEF_TAB[k])
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .valid_in  (valid_s[k]),
                .acc_in    (acc_in),
                .fp_in     (fp_s[k]),
                .side_in   (side_s[k]),
                .valid_out (valid_s[k+1]),
                .acc_out   (acc_s[k+1]),
                .side_out  (side_s[k+1])
            );
        end
    endgenerate

    // The polynomial is never below one, so the subtraction cannot wrap.
    always_comb
    begin
        frac_full = acc_s[4] - ONE;
        if (frac_full[ACC_W-1:P] != '0) begin
            frac_sat = '1;
        end else begin
            frac_sat = frac_full[P-1:0];
        end
    end

    generate
        if (P > MB) begin : g_mant_round
            localparam int SH = P - MB;
            logic [P:0] mant_rnd;
            logic [P:0] mant_shift;
            always_comb
            begin
                mant_rnd   = {1'b0, frac_sat} + ((P + 1)'(1) << (SH - 1));
                mant_shift = mant_rnd >> SH;
                // A rounding carry into the hidden bit saturates the mantissa.
                if (mant_shift[MB]) begin
                    mant = '1;
                end else begin
                    mant = mant_shift[MB-1:0];
                end
            end
        end else if (P == MB) begin : g_mant_exact
            assign mant = MB'(frac_sat);
        end else begin : g_mant_widen
            assign mant = MB'(frac_sat) << (MB - P);
        end
    endgenerate

    always_comb
    begin
        out_next.last_out  = side_s[4].last;
        out_next.underflow = side_s[4].uflow;
        if (side_s[4].uflow) begin
            out_next.result_bits = '0;
        end else if (side_s[4].oflow) begin
            out_next.result_bits = e2p_pkg::FLOAT_POS_INF;
        end else begin
            out_next.result_bits = {1'b0, side_s[4].exp_field, mant};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= valid_s[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for exp2_poly_approx: a table of directed arguments, then random ones.
// Table rows with known set are compared against their typed results; every other result against an in-bench model.
// Depends on e2p_pkg and the exp2_poly_approx RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int X_WIDTH        = e2p_pkg::X_WIDTH;
    localparam int FRAC_BITS      = 16;
    localparam int POLY_FRAC_BITS = 24;
    localparam int INT_BITS       = X_WIDTH - FRAC_BITS;
    localparam int RANDOM_ITEMS   = 600;
    localparam int DRAIN_AT       = 300;
    localparam int STEADY_FIRST   = 150;
    localparam int STEADY_LAST    = 230;
    localparam int MAX_WAIT       = 6;
    localparam int PIPE_LATENCY   = 6;
    localparam int CYCLE_LIMIT    = 200000;

    typedef struct packed {
        logic [X_WIDTH-1:0] x;
        logic               last;
        logic               known;
        logic [31:0]        bits;
        logic               uflow;
    } arg_row_t;

    localparam int NUM_ROWS = 16;
    // Rows with known set carry a result that follows directly from the exponent alone.
    localparam arg_row_t ARG_TABLE [NUM_ROWS] = '{
        '{24'h000000, 1'b0, 1'b1, 32'h3F80_0000, 1'b0},  // 2^0
        '{24'h010000, 1'b1, 1'b1, 32'h4000_0000, 1'b0},  // 2^1
        '{24'hFF0000, 1'b0, 1'b1, 32'h3F00_0000, 1'b0},  // 2^-1
        '{24'h7F0000, 1'b0, 1'b1, 32'h7F00_0000, 1'b0},  // largest exponent
        '{24'h820000, 1'b1, 1'b1, 32'h0080_0000, 1'b0},  // smallest normal
        '{24'h81FFFF, 1'b0, 1'b1, 32'h0000_0000, 1'b1},  // just below -126
        '{24'h810000, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
        '{24'h800000, 1'b1, 1'b1, 32'h0000_0000, 1'b1},  // most negative argument
        '{24'h7FFFFF, 1'b0, 1'b0, 32'h0,         1'b0},  // most positive argument
        '{24'h00FFFF, 1'b0, 1'b0, 32'h0,         1'b0},  // fraction all ones
        '{24'h008000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'h000001, 1'b1, 1'b0, 32'h0,         1'b0},
        '{24'hFFFFFF, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'h82FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'h555555, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'hAAAAAA, 1'b1, 1'b0, 32'h0,         1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    e2p_pkg::e2p_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    e2p_pkg::e2p_out_t out_data;

    e2p_pkg::e2p_out_t pending_results [$];
    int       mismatch_count;
    int       items_sent;
    int       results_checked;
    int       underflows_seen;
    int       cycle_count;
    int       stall_left;
    bit       steady;

    exp2_poly_approx #(
        .FRAC_BITS      (FRAC_BITS),
        .POLY_FRAC_BITS (POLY_FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Rounds a 2^30-scaled coefficient half up to the polynomial precision.
    function automatic logic [63:0] q30_to_poly(input logic [29:0] c30);
        int sh;
        sh = 30 - POLY_FRAC_BITS;
        if (sh == 0)
        begin
            return 64'(c30);
        end
        return (64'(c30) + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [63:0] horner_mul(input logic [63:0] acc, input logic [63:0] f);
        return (acc * f + (64'd1 << (POLY_FRAC_BITS - 1))) >> POLY_FRAC_BITS;
    endfunction

    function automatic e2p_pkg::e2p_out_t exp2_expected(input e2p_pkg::e2p_in_t item);
        logic signed [X_WIDTH-1:0] xs;
        longint                    ipart;
        longint                    biased;
        logic [63:0]               frac_in;
        logic [63:0]               f_poly;
        logic [63:0]               one;
        logic [63:0]               acc;
        logic [63:0]               poly_frac;
        logic [63:0]               mant;
        e2p_pkg::e2p_out_t         res;
        xs      = item.x_value;
        ipart   = longint'(xs) >>> FRAC_BITS;
        frac_in = 64'(xs) & ((64'd1 << FRAC_BITS) - 1);
        if (POLY_FRAC_BITS >= FRAC_BITS)
        begin
            f_poly = frac_in << (POLY_FRAC_BITS - FRAC_BITS);
        end
        else
        begin
            f_poly = frac_in >> (FRAC_BITS - POLY_FRAC_BITS);
        end
        one       = 64'd1 << POLY_FRAC_BITS;
        acc       = q30_to_poly(e2p_pkg::COEF4_Q30);
        acc       = horner_mul(acc, f_poly) + q30_to_poly(e2p_pkg::COEF3_Q30);
        acc       = horner_mul(acc, f_poly) + q30_to_poly(e2p_pkg::COEF2_Q30);
        acc       = horner_mul(acc, f_poly) + q30_to_poly(e2p_pkg::COEF1_Q30);
        // The polynomial minus one is the last product itself.
        poly_frac = horner_mul(acc, f_poly);
        if (poly_frac > one - 1)
        begin
            poly_frac = one - 1;
        end
        if (POLY_FRAC_BITS > e2p_pkg::MANT_BITS)
        begin
            mant = (poly_frac + (64'd1 << (POLY_FRAC_BITS - e2p_pkg::MANT_BITS - 1)))
                   >> (POLY_FRAC_BITS - e2p_pkg::MANT_BITS);
        end
        else
        begin
            mant = poly_frac << (e2p_pkg::MANT_BITS - POLY_FRAC_BITS);
        end
        if (mant > (64'd1 << e2p_pkg::MANT_BITS) - 1)
        begin
            mant = (64'd1 << e2p_pkg::MANT_BITS) - 1;
        end
        biased        = ipart + e2p_pkg::EXP_BIAS;
        res.last_out  = item.last_item;
        res.underflow = 1'b0;
        if (ipart < e2p_pkg::EXP_MIN)
        begin
            res.result_bits = 32'd0;
            res.underflow   = 1'b1;
        end
        else if (biased > e2p_pkg::EXP_MAX + e2p_pkg::EXP_BIAS)
        begin
            res.result_bits = e2p_pkg::FLOAT_POS_INF;
        end
        else
        begin
            res.result_bits = {1'b0, 8'(biased), 23'(mant)};
        end
        return res;
    endfunction

    function automatic e2p_pkg::e2p_in_t random_arg();
        e2p_pkg::e2p_in_t item;
        int      ival;
        int      fr;
        int      pick;
        pick = $urandom_range(0, 9);
        fr   = $urandom_range(0, (1 << FRAC_BITS) - 1);
        ival = $urandom_range(0, (1 << INT_BITS) - 1) - (1 << (INT_BITS - 1));
        if (pick == 4 || pick == 5)
        begin
            // Near either end of the exponent range.
            ival = ($urandom_range(0, 1) == 1) ? $urandom_range(125, 127)
                                               : -$urandom_range(124, 128);
        end
        else if (pick == 6)
        begin
            case ($urandom_range(0, 5))
                0: fr = 0;
                1: fr = 1;
                2: fr = (1 << (FRAC_BITS - 1)) - 1;
                3: fr = 1 << (FRAC_BITS - 1);
                4: fr = (1 << FRAC_BITS) - 2;
                default: fr = (1 << FRAC_BITS) - 1;
            endcase
        end
        else if (pick >= 7)
        begin
            ival = $urandom_range(0, 16) - 8;
        end
        item.x_value = X_WIDTH'(ival <<< FRAC_BITS) | X_WIDTH'(fr);
        if (pick <= 3)
        begin
            item.x_value = X_WIDTH'($urandom);
        end
        item.last_item = ($urandom_range(0, 3) == 0);
        return item;
    endfunction

    task automatic drive_arg(input e2p_pkg::e2p_in_t item, input bit known,
                             input e2p_pkg::e2p_out_t typed_res);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_results.push_back(known ? typed_res : exp2_expected(item));
        items_sent++;
    endtask

    task automatic check_result(input e2p_pkg::e2p_out_t got);
        e2p_pkg::e2p_out_t want;
        if (pending_results.size() == 0)
        begin
            $error("result 0x%08h arrived with nothing expected", got.result_bits);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.result_bits !== want.result_bits)
        begin
            $error("result_bits: expected 0x%08h, got 0x%08h", want.result_bits, got.result_bits);
            mismatch_count++;
        end
        if (got.underflow !== want.underflow)
        begin
            $error("underflow: expected %0b, got %0b", want.underflow, got.underflow);
            mismatch_count++;
        end
        if (got.last_out !== want.last_out)
        begin
            $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
            mismatch_count++;
        end
        results_checked++;
        if (got.underflow === 1'b1)
        begin
            underflows_seen++;
        end
    endtask

    // Receiver: after each item taken, hold out_ready low for a random number of cycles.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result(out_data);
                stall_left = steady ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_ready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("** exp2_poly_approx: FAILED **");
            $finish;
        end
    end

    initial
    begin
        e2p_pkg::e2p_in_t  item;
        e2p_pkg::e2p_out_t typed_res;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        in_data         <= '0;
        cycle_count     = 0;
        mismatch_count  = 0;
        items_sent      = 0;
        results_checked = 0;
        underflows_seen = 0;
        steady          = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            item.x_value          = ARG_TABLE[i].x;
            item.last_item        = ARG_TABLE[i].last;
            typed_res.result_bits = ARG_TABLE[i].bits;
            typed_res.underflow   = ARG_TABLE[i].uflow;
            typed_res.last_out    = ARG_TABLE[i].last;
            drive_arg(item, ARG_TABLE[i].known, typed_res);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= STEADY_FIRST && i < STEADY_LAST);
            if (i == DRAIN_AT)
            begin
                // Let the pipeline empty completely before resuming.
                in_valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (pending_results.size() != 0);
            end
            drive_arg(random_arg(), 1'b0, typed_res);
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY * 2) @(posedge clk);

        $display("Sent %0d arguments (%0d from the table), checked %0d results, %0d underflows.",
                 items_sent, NUM_ROWS, results_checked, underflows_seen);
        $display("%0d field mismatches over %0d cycles.", mismatch_count, cycle_count);
        if (mismatch_count == 0)
        begin
            $display("** exp2_poly_approx: PASSED **");
        end
        else
        begin
            $display("** exp2_poly_approx: FAILED **");
        end
        $finish;
    end

endmodule

FILE: exp2_poly_approx.f
design/e2p_pkg.sv
design/e2p_horner_stage.sv
design/exp2_poly_approx.sv
verif/tb.sv
